// ===== rtl/oaht_pkg.sv =====
package oaht_pkg;

  // Table geometry: slot count is a power of two so the start slot is the low hash bits
  localparam int unsigned TABLE_SLOTS = 256;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LOAD_W   = 9;

  localparam logic [LOAD_W-1:0] LOAD_LIMIT_RST = 9'd192;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_PROBE = 2'd1,
    S_ACT   = 2'd2
  } state_e;

  // One table slot as stored in the slot memory
  typedef struct packed {
    logic             tomb;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

// ===== rtl/oaht_if.sv =====
interface oaht_in_if
  import oaht_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key_id;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  value_in;

  modport source (output valid, cmd, key_id, key_hash, value_in, input ready);
  modport sink (input valid, cmd, key_id, key_hash, value_in, output ready);
endinterface

interface oaht_out_if
  import oaht_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                is_new_key;
  logic [VAL_W-1:0]    value_out;

  modport source (output valid, status, is_new_key, value_out, input ready);
  modport sink (input valid, status, is_new_key, value_out, output ready);
endinterface

// ===== rtl/open_addressing_hash_table.sv =====
// Key/value table with linear probing and tombstones over TABLE_SLOTS slots held in one
// slot memory with one read and one write port. Each request word (set, get or delete) starts probing at the
// low bits of key_hash and a small sequencer reads one slot per cycle until it finds the
// key, an empty slot or has gone once around the table, probing 1 to TABLE_SLOTS slots.
// The next request is taken only once this one has been through the probe walk and the
// update step; a zero key or an unused command skips the walk. The response word comes
// out of its own register, so a waiting response does not stop the table from taking the
// next request, though it holds that request's update step. Per-slot valid flops make
// every slot read as empty right after reset, so there is no clearing pass.
// load_limit may be written only while the table is idle.
module open_addressing_hash_table
  import oaht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LOAD_W-1:0] cfg_wdata_i,
  oaht_in_if.sink           req_i,
  oaht_out_if.source        rsp_o
);

  state_e state_q, state_d;

  // Request word held for the whole operation
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic             nop_q, nop_d;

  // Probe walk
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              have_tomb_q, have_tomb_d;
  logic [SLOT_W-1:0] tomb_idx_q, tomb_idx_d;

  // Probe outcome
  logic              hit_q, hit_d;
  logic              ins_ok_q, ins_ok_d;
  logic              ins_tomb_q, ins_tomb_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [VAL_W-1:0]  hit_val_q, hit_val_d;

  // Slot memory and per-slot valid flops
  slot_t             slot_mem_q [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_vld_q;
  slot_t             rd_q;
  logic              rd_vld_q;
  slot_t             cur;
  logic              mem_we;
  slot_t             mem_wdata;

  logic [LOAD_W-1:0] load_limit_q;
  logic [LOAD_W-1:0] used_q, used_d;

  // Response register
  logic                rsp_vld_q;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic                rsp_new_q, rsp_new_d;
  logic [VAL_W-1:0]    rsp_val_q, rsp_val_d;
  logic                act_go;
  logic                accept;

  logic cur_empty, cur_tomb, cur_hit, tomb_seen, lap_last;
  logic [SLOT_W-1:0] tomb_at;

  assign accept   = req_i.valid && req_i.ready;
  assign act_go   = (state_q == S_ACT) && (!rsp_vld_q || rsp_o.ready);
  assign lap_last = &cnt_q;

  // Slot under inspection; a never-written slot reads as empty
  assign cur       = rd_vld_q ? rd_q : '0;
  assign cur_empty = (cur.key == '0) && !cur.tomb;
  assign cur_tomb  = (cur.key == '0) && cur.tomb;
  assign cur_hit   = (cur.key != '0) && (cur.key == key_q);
  assign tomb_seen = have_tomb_q || cur_tomb;
  assign tomb_at   = have_tomb_q ? tomb_idx_q : idx_q;

  // State register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      load_limit_q <= LOAD_LIMIT_RST;
      slot_vld_q   <= '0;
      rsp_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        load_limit_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        slot_vld_q[slot_q] <= 1'b1;
      end
      if (act_go) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key_id;
      val_q <= req_i.value_in;
    end
    nop_q       <= nop_d;
    idx_q       <= idx_d;
    cnt_q       <= cnt_d;
    have_tomb_q <= have_tomb_d;
    tomb_idx_q  <= tomb_idx_d;
    hit_q       <= hit_d;
    ins_ok_q    <= ins_ok_d;
    ins_tomb_q  <= ins_tomb_d;
    slot_q      <= slot_d;
    hit_val_q   <= hit_val_d;
    if (act_go) begin
      rsp_status_q <= rsp_status_d;
      rsp_new_q    <= rsp_new_d;
      rsp_val_q    <= rsp_val_d;
    end
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[slot_q] <= mem_wdata;
    end
    rd_q     <= slot_mem_q[idx_d];
    rd_vld_q <= slot_vld_q[idx_d];
  end

  // Sequencer: accept, walk the slots, then update the table and load the response
  always_comb begin
    state_d      = state_q;
    nop_d        = nop_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    have_tomb_d  = have_tomb_q;
    tomb_idx_d   = tomb_idx_q;
    hit_d        = hit_q;
    ins_ok_d     = ins_ok_q;
    ins_tomb_d   = ins_tomb_q;
    slot_d       = slot_q;
    hit_val_d    = hit_val_q;
    used_d       = used_q;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    rsp_status_d = ST_MISSING;
    rsp_new_d    = 1'b0;
    rsp_val_d    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d       = req_i.key_hash[SLOT_W-1:0];
          cnt_d       = '0;
          have_tomb_d = 1'b0;
          hit_d       = 1'b0;
          ins_ok_d    = 1'b0;
          ins_tomb_d  = 1'b0;
          nop_d       = (req_i.key_id == '0) ||
                        !(req_i.cmd == CMD_SET || req_i.cmd == CMD_GET ||
                          req_i.cmd == CMD_DEL);
          state_d     = nop_d ? S_ACT : S_PROBE;
        end
      end

      S_PROBE: begin
        if (cur_hit) begin
          hit_d     = 1'b1;
          slot_d    = idx_q;
          hit_val_d = cur.value;
          state_d   = S_ACT;
        end else if (cur_empty) begin
          ins_ok_d   = 1'b1;
          ins_tomb_d = have_tomb_q;
          slot_d     = have_tomb_q ? tomb_idx_q : idx_q;
          state_d    = S_ACT;
        end else begin
          // Remember the first tombstone passed
          have_tomb_d = tomb_seen;
          tomb_idx_d  = tomb_at;
          if (lap_last) begin
            ins_ok_d   = tomb_seen;
            ins_tomb_d = tomb_seen;
            slot_d     = tomb_at;
            state_d    = S_ACT;
          end else begin
            idx_d = idx_q + 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      S_ACT: begin
        if (act_go) begin
          state_d = S_IDLE;
          if (!nop_q) begin
            case (cmd_q)
              CMD_SET: begin
                mem_wdata = '{tomb: 1'b0, key: key_q, value: val_q};
                if (hit_q) begin
                  mem_we       = 1'b1;
                  rsp_status_d = ST_OK;
                end else if (!ins_ok_q) begin
                  rsp_status_d = ST_FULL;
                end else if (ins_tomb_q) begin
                  mem_we       = 1'b1;
                  rsp_status_d = ST_OK;
                  rsp_new_d    = 1'b1;
                end else if (({1'b0, used_q} + 1'b1) > {1'b0, load_limit_q}) begin
                  rsp_status_d = ST_FULL;
                end else begin
                  mem_we       = 1'b1;
                  used_d       = used_q + 1'b1;
                  rsp_status_d = ST_OK;
                  rsp_new_d    = 1'b1;
                end
              end
              CMD_GET: begin
                if (hit_q) begin
                  rsp_status_d = ST_OK;
                  rsp_val_d    = hit_val_q;
                end
              end
              CMD_DEL: begin
                if (hit_q) begin
                  // Leave a tombstone
                  mem_we       = 1'b1;
                  mem_wdata    = '{tomb: 1'b1, key: '0, value: '0};
                  rsp_status_d = ST_OK;
                end
              end
              default: begin
                rsp_status_d = ST_MISSING;
              end
            endcase
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.is_new_key = rsp_new_q;
  assign rsp_o.value_out  = rsp_val_q;

`ifndef ASSERT_OFF
  // The used count only ever steps up by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> used_q == $past(used_q) + 1'b1)
    else $error("used count moved by other than one");

  // A fresh response word comes only out of the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !$past(rsp_o.valid) |-> $past(state_q == S_ACT))
    else $error("response raised outside update step");

  // The probe walk never runs past one lap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE && lap_last |=> state_q != S_PROBE)
    else $error("probe walk ran past one lap");

  // A new key is reported only with a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.is_new_key |-> rsp_o.status == ST_OK)
    else $error("new key flagged on failed operation");

  // The table is written only in the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_vld_q != $past(slot_vld_q) |-> $past(state_q == S_ACT))
    else $error("slot written outside update step");
`endif

endmodule
